// ----- rtl/kmrh_pkg.sv -----
// Shared types, constants and helper functions for the key matrix scanner.
// Used by kmrh_scan, kmrh_emit and key_matrix_repeat_holdoff; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kmrh_pkg;

	// Matrix geometry and key capture limits
	localparam int ROWS       = 8;
	localparam int COLS       = 5;
	localparam int MAX_KEYS   = 2;
	localparam int KEYS_TOTAL = ROWS * COLS;

	// Field widths
	localparam int MATRIX_W   = 40;
	localparam int TIME_W     = 32;
	localparam int KEY_W      = 6;
	localparam int HOLDOFF_W  = 16;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 8;
	localparam int USER_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Position code for an empty slot
	localparam logic [KEY_W-1:0] NO_KEY = KEY_W'(40);

	// Register reset values
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET = HOLDOFF_W'(400);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_RESET_POS = CFG_IDX_W'(1);

	// One run of events produced by a scan
	typedef struct packed {
		logic [KEY_W-1:0] key0;
		logic [KEY_W-1:0] key1;
		logic             two_keys;
		logic             rst0;
		logic             rst1;
	} run_t;

	// Lowest set position, or NO_KEY when nothing is pressed
	function automatic logic [KEY_W-1:0] first_key(input logic [KEYS_TOTAL-1:0] bits);
		logic [KEY_W-1:0] pos;
		pos = NO_KEY;
		for (int i = KEYS_TOTAL - 1; i >= 0; i--) begin
			if (bits[i]) begin
				pos = KEY_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/key_matrix_repeat_holdoff.sv -----
// Key matrix scanner with repeat hold-off, top level. Depends on kmrh_pkg,
// kmrh_scan and kmrh_emit.
// Path: with the emitter free, the first event of a scan passes through the input
// register, then the output event register.
// Throughput: one scan per cycle while scans report nothing; a reported scan
// holds the single output event register for its 2 or 4 events, one per transaction.
// Reset: arst_n clears the scan history to no key, the emission time to zero,
// hold-off to 400 ms and the reset key position to none; ready right after.
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_repeat_holdoff (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Scan input
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [kmrh_pkg::IN_DATA_W-1:0]      s_tdata,  // [39:0] matrix_bits, [71:40] now_ms
	// Event output
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [kmrh_pkg::OUT_DATA_W-1:0]          m_tdata,  // [5:0] key_position, [7:6] zero
	output logic [kmrh_pkg::USER_W-1:0]              m_tuser,  // [0] pressed, [1] reset_request
	output logic                                     m_tlast,  // last_of_run
	// Configuration writes
	input  wire logic                                cfg_we,
	input  wire logic [kmrh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [kmrh_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [kmrh_pkg::HOLDOFF_W-1:0]  holdoff_q;
	logic [kmrh_pkg::KEY_W-1:0]      reset_pos_q;
	logic                            run_free;
	logic                            run_load;
	kmrh_pkg::run_t                  run;
	logic [kmrh_pkg::KEY_W-1:0]      key_position;
	logic                            pressed;
	logic                            reset_request;

	// Configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_q   <= kmrh_pkg::HOLDOFF_RESET;
			reset_pos_q <= kmrh_pkg::NO_KEY;
		end else if (cfg_we) begin
			case (cfg_index)
				kmrh_pkg::REG_HOLDOFF: begin
					holdoff_q <= cfg_data;
				end
				kmrh_pkg::REG_RESET_POS: begin
					reset_pos_q <= cfg_data[kmrh_pkg::KEY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	kmrh_scan u_scan (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (s_tvalid),
		.in_ready           (s_tready),
		.matrix_bits        (s_tdata[kmrh_pkg::MATRIX_W-1:0]),
		.now_ms             (s_tdata[kmrh_pkg::IN_DATA_W-1:kmrh_pkg::MATRIX_W]),
		.holdoff_ms         (holdoff_q),
		.reset_key_position (reset_pos_q),
		.run_free           (run_free),
		.run_load           (run_load),
		.run                (run)
	);

	kmrh_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.run_load      (run_load),
		.run           (run),
		.run_free      (run_free),
		.ev_valid      (m_tvalid),
		.ev_ready      (m_tready),
		.key_position  (key_position),
		.pressed       (pressed),
		.reset_request (reset_request),
		.last_of_run   (m_tlast)
	);

	// Pack the event fields
	assign m_tdata = {(kmrh_pkg::OUT_DATA_W - kmrh_pkg::KEY_W)'(0), key_position};
	assign m_tuser = {reset_request, pressed};

endmodule

`default_nettype wire

// ----- rtl/kmrh_scan.sv -----
// Scan stage: input register, capture of the first pressed keys, hold-off decision
// and scan history. Depends on kmrh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmrh_scan (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [kmrh_pkg::MATRIX_W-1:0]     matrix_bits,
	input  wire logic [kmrh_pkg::TIME_W-1:0]       now_ms,
	input  wire logic [kmrh_pkg::HOLDOFF_W-1:0]    holdoff_ms,
	input  wire logic [kmrh_pkg::KEY_W-1:0]        reset_key_position,
	input  wire logic                              run_free,
	output logic                                   run_load,
	output kmrh_pkg::run_t                         run
);

	logic                              valid_s1;
	logic [kmrh_pkg::MATRIX_W-1:0]     matrix_s1;
	logic [kmrh_pkg::TIME_W-1:0]       now_s1;

	logic [kmrh_pkg::KEY_W-1:0]        prev_key0_q;
	logic [kmrh_pkg::KEY_W-1:0]        prev_key1_q;
	logic [kmrh_pkg::TIME_W-1:0]       last_emit_q;

	logic [kmrh_pkg::KEYS_TOTAL-1:0]   scan_bits;
	logic [kmrh_pkg::KEYS_TOTAL-1:0]   rest_bits;
	logic [kmrh_pkg::KEY_W-1:0]        key0;
	logic [kmrh_pkg::KEY_W-1:0]        key1;
	logic [kmrh_pkg::TIME_W-1:0]       elapsed;
	logic                              any_key;
	logic                              same_keys;
	logic                              emit;
	logic                              advance;

	// Capture the first two pressed positions in row-major order
	always_comb begin
		scan_bits = matrix_s1[kmrh_pkg::KEYS_TOTAL-1:0];
		rest_bits = scan_bits & (scan_bits - kmrh_pkg::KEYS_TOTAL'(1));
		key0      = kmrh_pkg::first_key(scan_bits);
		key1      = (kmrh_pkg::MAX_KEYS >= 2) ? kmrh_pkg::first_key(rest_bits)
		                                      : kmrh_pkg::NO_KEY;
	end

	// Decide whether this scan is reported or held off
	always_comb begin
		any_key   = (key0 != kmrh_pkg::NO_KEY);
		same_keys = any_key && (key0 == prev_key0_q) && (key1 == prev_key1_q);
		elapsed   = now_s1 - last_emit_q;
		emit      = any_key &&
		            !(same_keys && (elapsed < kmrh_pkg::TIME_W'(holdoff_ms)));
		advance   = valid_s1 && (!emit || run_free);
		in_ready  = !valid_s1 || advance;
		run_load  = advance && emit;
	end

	// Build the run handed to the emitter
	always_comb begin
		run.key0     = key0;
		run.key1     = key1;
		run.two_keys = (key1 != kmrh_pkg::NO_KEY);
		run.rst0     = (key0 == reset_key_position);
		run.rst1     = (key1 == reset_key_position);
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			matrix_s1 <= matrix_bits;
			now_s1    <= now_ms;
		end
	end

	// Scan history and last emission time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_key0_q <= kmrh_pkg::NO_KEY;
			prev_key1_q <= kmrh_pkg::NO_KEY;
			last_emit_q <= '0;
		end else if (advance) begin
			prev_key0_q <= key0;
			prev_key1_q <= key1;
			if (emit) begin
				last_emit_q <= now_s1;
			end
		end
	end

	// Stored keys follow the scan that just left the stage
	a_history: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (prev_key0_q == $past(key0)) && (prev_key1_q == $past(key1)))
		else $error("scan history not updated");

	// Emission time follows a reported scan
	a_emit_time: assert property (@(posedge clk) disable iff (!arst_n)
		run_load |=> last_emit_q == $past(now_s1))
		else $error("last emission time not recorded");

	// A run is handed over only to a free emitter
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		run_load |-> run_free)
		else $error("run loaded into busy emitter");

endmodule

`default_nettype wire

// ----- rtl/kmrh_emit.sv -----
// Event emitter: holds one run and issues its press and release events one per
// transaction. Depends on kmrh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kmrh_emit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       run_load,
	input  wire kmrh_pkg::run_t             run,
	output logic                            run_free,
	output logic                            ev_valid,
	input  wire logic                       ev_ready,
	output logic [kmrh_pkg::KEY_W-1:0]      key_position,
	output logic                            pressed,
	output logic                            reset_request,
	output logic                            last_of_run
);

	logic            valid_q;
	kmrh_pkg::run_t  run_q;
	logic [1:0]      idx_q;
	logic            sel_second;

	// Decode the current event from the run and its index
	always_comb begin
		if (run_q.two_keys) begin
			sel_second  = idx_q[0];
			pressed     = !idx_q[1];
			last_of_run = (idx_q == 2'd3);
		end else begin
			sel_second  = 1'b0;
			pressed     = !idx_q[0];
			last_of_run = (idx_q == 2'd1);
		end
		key_position  = sel_second ? run_q.key1 : run_q.key0;
		reset_request = pressed && (sel_second ? run_q.rst1 : run_q.rst0);
		ev_valid      = valid_q;
		run_free      = !valid_q || (ev_ready && last_of_run);
	end

	// Advance through the run, load the next one when idle or when the last event goes out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (run_free) begin
			valid_q <= run_load;
			idx_q   <= 2'd0;
		end else if (ev_ready) begin
			idx_q   <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (run_free && run_load) begin
			run_q <= run;
		end
	end

	// A single-key run never walks past its release event
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !run_q.two_keys) |-> (idx_q == 2'd0 || idx_q == 2'd1))
		else $error("event index beyond single-key run");

	// Reset request only rides on press events
	a_rst_press: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && reset_request) |-> pressed)
		else $error("reset request on release event");

	// Every run starts at its first press event
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(run_free && run_load) |=> (valid_q && idx_q == 2'd0))
		else $error("run did not start at first event");

endmodule

`default_nettype wire

// ----- tb/kmrh_event_checker.sv -----
// Event checker for the key matrix scanner: watches the scan, event and
// configuration ports, predicts the event stream and compares it. Needs kmrh_pkg.
`timescale 1ns / 1ps

module kmrh_event_checker (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_tvalid,
	input  wire logic                                s_tready,
	input  wire logic [kmrh_pkg::IN_DATA_W-1:0]      s_tdata,   // [39:0] matrix_bits, [71:40] now_ms
	input  wire logic                                m_tvalid,
	input  wire logic                                m_tready,
	input  wire logic [kmrh_pkg::OUT_DATA_W-1:0]     m_tdata,   // [5:0] key_position, [7:6] zero
	input  wire logic [kmrh_pkg::USER_W-1:0]         m_tuser,   // [0] pressed, [1] reset_request
	input  wire logic                                m_tlast,
	input  wire logic                                cfg_we,
	input  wire logic [kmrh_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [kmrh_pkg::CFG_DATA_W-1:0]     cfg_data,
	output int                                       mismatch_count,
	output int                                       events_due
);
	import kmrh_pkg::*;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             pressed;
		logic             reset_req;
		logic             last;
	} key_event_t;

	key_event_t           key_events_due[$];
	logic [HOLDOFF_W-1:0] holdoff_ms   = HOLDOFF_RESET;
	logic [KEY_W-1:0]     reset_pos    = NO_KEY;
	logic [KEY_W-1:0]     prev_first   = NO_KEY;
	logic [KEY_W-1:0]     prev_second  = NO_KEY;
	logic [TIME_W-1:0]    last_emit_ms = '0;

	// Capture the first two pressed keys and queue the press/release run they cause
	task automatic scan_to_events(input logic [IN_DATA_W-1:0] scan);
		logic [MATRIX_W-1:0] bits;
		logic [TIME_W-1:0]   now;
		logic [TIME_W-1:0]   elapsed;
		logic [KEY_W-1:0]    keys [2];
		int                  count;
		bit                  unchanged;
		key_event_t          ev;
		bits    = scan[MATRIX_W-1:0];
		now     = scan[MATRIX_W +: TIME_W];
		keys[0] = NO_KEY;
		keys[1] = NO_KEY;
		count   = 0;
		for (int pos = 0; pos < KEYS_TOTAL; pos++) begin
			if (bits[pos] && count < MAX_KEYS) begin
				keys[count] = KEY_W'(pos);
				count++;
			end
		end
		// Suppress an unchanged key set inside the hold-off window
		unchanged = count > 0 && keys[0] == prev_first && keys[1] == prev_second;
		elapsed   = now - last_emit_ms;
		if (unchanged && elapsed < TIME_W'(holdoff_ms)) begin
			count = 0;
		end
		if (count > 0) begin
			last_emit_ms = now;
			for (int k = 0; k < count; k++) begin
				ev.key       = keys[k];
				ev.pressed   = 1'b1;
				ev.reset_req = keys[k] == reset_pos;
				ev.last      = 1'b0;
				key_events_due.push_back(ev);
			end
			for (int k = 0; k < count; k++) begin
				ev.key       = keys[k];
				ev.pressed   = 1'b0;
				ev.reset_req = 1'b0;
				ev.last      = k == count - 1;
				key_events_due.push_back(ev);
			end
		end
		prev_first  = keys[0];
		prev_second = keys[1];
	endtask

	// Compare one output transaction against the oldest queued event
	task automatic check_event();
		key_event_t want;
		if (key_events_due.size() == 0) begin
			if (mismatch_count < 10) begin
				$display("unexpected event: key %0d pressed %0b reset_req %0b last %0b",
					m_tdata, m_tuser[0], m_tuser[1], m_tlast);
			end
			mismatch_count++;
		end else begin
			want = key_events_due.pop_front();
			if (m_tdata != OUT_DATA_W'(want.key) || m_tuser[0] != want.pressed ||
					m_tuser[1] != want.reset_req || m_tlast != want.last) begin
				if (mismatch_count < 10) begin
					$display("event mismatch: expected key %0d pressed %0b reset_req %0b last %0b",
						want.key, want.pressed, want.reset_req, want.last);
					$display("                got      key %0d pressed %0b reset_req %0b last %0b",
						m_tdata, m_tuser[0], m_tuser[1], m_tlast);
				end
				mismatch_count++;
			end
		end
	endtask

	// Track configuration, predict on each scan transaction, check each event
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_ms     = HOLDOFF_RESET;
			reset_pos      = NO_KEY;
			prev_first     = NO_KEY;
			prev_second    = NO_KEY;
			last_emit_ms   = '0;
			mismatch_count = 0;
			key_events_due.delete();
			events_due     = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HOLDOFF: begin
						holdoff_ms = cfg_data[HOLDOFF_W-1:0];
					end
					REG_RESET_POS: begin
						reset_pos = cfg_data[KEY_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				scan_to_events(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				check_event();
			end
			events_due = key_events_due.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the key matrix scanner testbench: clock, reset, scan stimulus,
// configuration and event back-pressure. Needs kmrh_pkg, the block and kmrh_event_checker.
`timescale 1ns / 1ps

module testbench;
	import kmrh_pkg::*;

	localparam int                   CYCLE_LIMIT     = 200000;
	localparam int                   SETTLE_CYCLES   = 12;
	localparam int                   RANDOM_PHASES   = 6;
	localparam int                   SCANS_PER_PHASE = 54;
	localparam int                   LONG_STALL      = 200;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE       = CFG_IDX_W'(3);

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [USER_W-1:0]     m_tuser;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int                    mismatch_count;
	int                    events_due;
	int                    cycle_count = 0;
	bit                    tx_idle_en = 1'b1;
	bit                    rx_idle_en = 1'b1;
	bit                    long_stall_req = 1'b0;
	logic [HOLDOFF_W-1:0]  cur_holdoff = HOLDOFF_RESET;
	logic [KEY_W-1:0]      cur_reset_pos = NO_KEY;

	key_matrix_repeat_holdoff dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	kmrh_event_checker event_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.m_tlast        (m_tlast),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.events_due     (events_due)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Event receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int hold;
		hold     = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				hold           = LONG_STALL;
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				hold     = $urandom_range(0, 9);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offer one scan, hold it until the transaction completes; returns at a falling edge
	task automatic send_scan(input logic [MATRIX_W-1:0] bits, input logic [TIME_W-1:0] now);
		int gap;
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			gap      = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {now, bits};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// Write both registers, and now and then the unused index
	task automatic set_config(input logic [HOLDOFF_W-1:0] holdoff, input logic [KEY_W-1:0] pos);
		write_reg(REG_HOLDOFF, CFG_DATA_W'(holdoff));
		write_reg(REG_RESET_POS, CFG_DATA_W'(pos));
		if ($urandom_range(0, 1) == 0) begin
			write_reg(REG_SPARE, CFG_DATA_W'($urandom));
		end
		cur_holdoff   = holdoff;
		cur_reset_pos = pos;
	endtask

	// Drop valid and wait until every predicted event is out and the block is quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		while (events_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly held key sets, with fresh sets, empty scans and noise mixed in
	function automatic logic [MATRIX_W-1:0] pick_scan_bits(input logic [MATRIX_W-1:0] held);
		logic [MATRIX_W-1:0] bits;
		int                  a;
		int                  b;
		bits = '0;
		a    = $urandom_range(0, KEYS_TOTAL - 1);
		b    = $urandom_range(0, KEYS_TOTAL - 1);
		if (cur_reset_pos < KEYS_TOTAL && $urandom_range(0, 3) == 0) begin
			a = cur_reset_pos;
		end
		case ($urandom_range(0, 9))
			0: begin
				bits = '0;
			end
			1: begin
				bits[a] = 1'b1;
			end
			2: begin
				bits[a] = 1'b1;
				bits[b] = 1'b1;
			end
			3: begin
				bits = MATRIX_W'({$urandom, $urandom});
			end
			4: begin
				bits = held | (MATRIX_W'(1) << a);
			end
			default: begin
				bits = held;
			end
		endcase
		return bits;
	endfunction

	// Time advance clustered around the hold-off edge
	function automatic logic [TIME_W-1:0] pick_step_ms();
		logic [TIME_W-1:0] step;
		case ($urandom_range(0, 7))
			0: step = '0;
			1: step = $urandom;
			2: step = TIME_W'(cur_holdoff) - 1;
			3: step = TIME_W'(cur_holdoff);
			4, 5: step = TIME_W'($urandom_range(0, 2 * cur_holdoff + 2));
			default: step = TIME_W'($urandom_range(0, 300));
		endcase
		return step;
	endfunction

	// Main stimulus
	initial begin
		logic [TIME_W-1:0]    clock_ms;
		logic [MATRIX_W-1:0]  held_bits;
		logic [HOLDOFF_W-1:0] holdoff;
		logic [KEY_W-1:0]     pos;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: empty scan, hold-off edge, top key, full matrix
		send_scan(40'h0, 32'd0);
		send_scan(40'h1, 32'd0);
		send_scan(40'h1, 32'd399);
		send_scan(40'h1, 32'd400);
		send_scan(40'h80_0000_0000, 32'd401);
		send_scan(40'hFF_FFFF_FFFF, 32'd402);
		send_scan(40'hFF_FFFF_FFFF, 32'd403);
		send_scan(40'hC0_0000_0000, 32'd404);
		send_scan(40'h0, 32'd405);
		send_scan(40'hC0_0000_0000, 32'd406);
		drain();

		// Zero hold-off repeats every scan; reset key on the first position
		set_config(16'd0, 6'd0);
		send_scan(40'h1, 32'd406);
		send_scan(40'h1, 32'd406);
		send_scan(40'h21, 32'd406);
		drain();

		// Longest hold-off across the time wrap; reset key on the last position
		set_config(16'hFFFF, 6'd39);
		send_scan(40'h3, 32'hFFFF_FFF0);
		send_scan(40'h5, 32'hFFFF_FFF8);
		send_scan(40'h5, 32'h0000_0010);
		send_scan(40'h5, 32'h0000_FFF7);
		send_scan(40'h80_0010_0000, 32'h0001_0000);
		send_scan(40'h80_0000_0000, 32'h0001_0001);
		send_scan(40'h40_0000_0000, 32'h0001_0001);
		drain();

		// Random phases over several register settings
		clock_ms  = 32'h0001_0001;
		held_bits = 40'h40_0000_0000;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					holdoff = 16'd0;
					pos     = 6'd39;
				end
				1: begin
					holdoff = 16'hFFFF;
					pos     = 6'd0;
				end
				2: begin
					holdoff  = 16'd1;
					pos      = NO_KEY;
					clock_ms = 32'hFFFF_FF00;
				end
				3: begin
					holdoff = 16'd250;
					pos     = KEY_W'($urandom_range(0, KEYS_TOTAL));
				end
				4: begin
					holdoff = HOLDOFF_W'($urandom_range(0, 3000));
					pos     = KEY_W'($urandom_range(0, KEYS_TOTAL));
				end
				default: begin
					holdoff = HOLDOFF_RESET;
					pos     = KEY_W'($urandom_range(0, KEYS_TOTAL - 1));
				end
			endcase
			set_config(holdoff, pos);
			// Phase 4 floods the block while the receiver holds off; the last has no idling
			tx_idle_en = phase != 4 && phase != RANDOM_PHASES - 1;
			rx_idle_en = phase != RANDOM_PHASES - 1;
			if (phase == 4) begin
				long_stall_req = 1'b1;
			end
			for (int n = 0; n < SCANS_PER_PHASE; n++) begin
				clock_ms  = clock_ms + pick_step_ms();
				held_bits = pick_scan_bits(held_bits);
				send_scan(held_bits, clock_ms);
			end
			drain();
		end

		if (mismatch_count == 0 && events_due == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
